[rtl/core/gsi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_pkg
// Shared constants, control struct and exponent factor table for the
// Gaussian spot intensity pipeline.
// ----------------------------------------------------------------------------
package gsi_pkg;

    localparam int FRAME_SIDE_MAX = 1024;
    localparam int FRAME_SIZE_RST = 256;
    localparam int SPOT_SCALE_RST = 3277;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT_SCALE = 2'd1;
    localparam int FRAME_WR_W = 11;

    localparam int COORD_W = 16;
    localparam int PIX_W   = 10;
    localparam int LEVEL_W = 8;
    localparam int SCALE_W = 16;

    // Quotient of the exponent argument: 3 integer and 16 fraction bits
    localparam int T_BITS    = 19;
    localparam int FRAC_BITS = 16;
    localparam int E_W       = 17;

    typedef struct packed {
        logic vld;
        logic far;
        logic zsig;
        logic dz;
    } gsi_ctl_t;

    // exp(-2^(k-16)) in Q.16, rounded
    function automatic logic [15:0] exp_factor(input logic [4:0] k);
        logic [15:0] f;
        case (k)
            5'd0:    f = 16'd65535;
            5'd1:    f = 16'd65534;
            5'd2:    f = 16'd65532;
            5'd3:    f = 16'd65528;
            5'd4:    f = 16'd65520;
            5'd5:    f = 16'd65504;
            5'd6:    f = 16'd65472;
            5'd7:    f = 16'd65408;
            5'd8:    f = 16'd65280;
            5'd9:    f = 16'd65026;
            5'd10:   f = 16'd64520;
            5'd11:   f = 16'd63520;
            5'd12:   f = 16'd61565;
            5'd13:   f = 16'd57835;
            5'd14:   f = 16'd51039;
            5'd15:   f = 16'd39750;
            5'd16:   f = 16'd24109;
            5'd17:   f = 16'd8869;
            5'd18:   f = 16'd1200;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

[rtl/core/gsi_geom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_geom
// Six-stage front end: exact squared distance in 1/12288 pixel units,
// sigma, the divisor 18*sigma^2 and the far / zero-sigma flags.
// ----------------------------------------------------------------------------
module gsi_geom #(
    parameter int FS_W  = 11,
    parameter int DX_W  = 29,
    parameter int D2_W  = 57,
    parameter int SIG_W = 26,
    parameter int DEN_W = 57,
    parameter int REM_W = 60
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  en,
    input  wire                                  in_vld,
    input  wire  signed [gsi_pkg::COORD_W-1:0]   spot_x,
    input  wire  signed [gsi_pkg::COORD_W-1:0]   spot_y,
    input  wire  signed [gsi_pkg::COORD_W-1:0]   spot_width,
    input  wire         [gsi_pkg::PIX_W-1:0]     pixel_col,
    input  wire         [gsi_pkg::PIX_W-1:0]     pixel_row,
    input  wire         [FS_W-1:0]               frame_size,
    input  wire         [gsi_pkg::SCALE_W-1:0]   spot_scale,
    output gsi_pkg::gsi_ctl_t                    ctl_o,
    output logic        [REM_W-1:0]              rem_o,
    output logic        [DEN_W-1:0]              den_o
);
    import gsi_pkg::*;

    localparam int PR_W  = FS_W + 18;
    localparam int WS_W  = FS_W + 16;
    localparam int WSC_W = WS_W + SCALE_W;
    localparam int SQD_W = 2 * DX_W - 2;
    localparam int SQ_W  = 2 * SIG_W;
    localparam int PX_W  = 24;

    logic [6:1] vld_reg;

    // stage 1
    logic signed [16:0]     xs_c, ys_c, ws_c;
    logic        [15:0]     wmag_c;
    logic signed [FS_W:0]   sz_c;
    logic signed [PR_W-1:0] xprod_reg, yprod_reg;
    logic        [PX_W-1:0] colsc_reg, rowsc_reg;
    logic        [WS_W-1:0] wsz_reg;
    // stage 2
    logic signed [DX_W-1:0] dx_reg, dy_reg;
    logic        [WSC_W-1:0] wsc_reg;
    // stage 3
    logic signed [2*DX_W-1:0] px_c, py_c;
    logic        [SQD_W-1:0]  dx2_reg, dy2_reg;
    logic        [SIG_W-1:0]  sig_reg;
    // stage 4
    logic [D2_W-1:0] d2_s4_reg;
    logic [SQ_W-1:0] sq_reg;
    logic            zsig_s4_reg;
    // stage 5
    logic [D2_W-1:0]  d2_s5_reg;
    logic [DEN_W-1:0] den_s5_reg;
    logic             zsig_s5_reg, dz_s5_reg;
    // stage 6
    logic [DEN_W+2:0] den7_c;
    logic [REM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             zsig_reg, dz_reg, far_reg;

    assign xs_c   = $signed({spot_x[15], spot_x}) + 17'sd6144;
    assign ys_c   = 17'sd6144 - $signed({spot_y[15], spot_y});
    assign ws_c   = $signed({spot_width[15], spot_width}) + 17'sd6144;
    assign wmag_c = ws_c[16] ? 16'(-ws_c) : ws_c[15:0];
    assign sz_c   = $signed({1'b0, frame_size});

    assign px_c   = (2*DX_W)'(dx_reg) * (2*DX_W)'(dx_reg);
    assign py_c   = (2*DX_W)'(dy_reg) * (2*DX_W)'(dy_reg);
    assign den7_c = ((DEN_W+3)'(den_s5_reg) << 3) - (DEN_W+3)'(den_s5_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:1], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xprod_reg   <= PR_W'(xs_c) * PR_W'(sz_c);
            yprod_reg   <= PR_W'(ys_c) * PR_W'(sz_c);
            // col * 12288 = col * 3 << 12
            colsc_reg   <= {1'b0, pixel_col, 13'b0} + {2'b0, pixel_col, 12'b0};
            rowsc_reg   <= {1'b0, pixel_row, 13'b0} + {2'b0, pixel_row, 12'b0};
            wsz_reg     <= WS_W'(wmag_c) * WS_W'(frame_size);

            dx_reg      <= DX_W'($signed({1'b0, colsc_reg})) - DX_W'(xprod_reg);
            dy_reg      <= DX_W'($signed({1'b0, rowsc_reg})) - DX_W'(yprod_reg);
            wsc_reg     <= WSC_W'(wsz_reg) * WSC_W'(spot_scale);

            dx2_reg     <= px_c[SQD_W-1:0];
            dy2_reg     <= py_c[SQD_W-1:0];
            sig_reg     <= wsc_reg[WSC_W-1:17];

            d2_s4_reg   <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
            sq_reg      <= SQ_W'(sig_reg) * SQ_W'(sig_reg);
            zsig_s4_reg <= (sig_reg == '0);

            d2_s5_reg   <= d2_s4_reg;
            den_s5_reg  <= (DEN_W'(sq_reg) << 4) + (DEN_W'(sq_reg) << 1);
            zsig_s5_reg <= zsig_s4_reg;
            dz_s5_reg   <= (d2_s4_reg == '0);

            rem_reg     <= REM_W'(d2_s5_reg);
            den_reg     <= den_s5_reg;
            zsig_reg    <= zsig_s5_reg;
            dz_reg      <= dz_s5_reg;
            far_reg     <= ((DEN_W+3)'(d2_s5_reg) >= den7_c) || (D2_W > DEN_W + 3 &&
                           (d2_s5_reg >> (DEN_W + 3)) != '0);
        end
    end

    assign ctl_o = '{vld: vld_reg[6], far: far_reg, zsig: zsig_reg, dz: dz_reg};
    assign rem_o = rem_reg;
    assign den_o = den_reg;

endmodule
`default_nettype wire

[rtl/core/gsi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_div
// Restoring divider, one quotient bit per stage: t = d2 / den in Q3.16,
// valid when d2 < 7*den.
// ----------------------------------------------------------------------------
module gsi_div #(
    parameter int DEN_W = 57,
    parameter int REM_W = 60
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             en,
    input  wire  gsi_pkg::gsi_ctl_t         ctl_i,
    input  wire  [REM_W-1:0]                rem_i,
    input  wire  [DEN_W-1:0]                den_i,
    output gsi_pkg::gsi_ctl_t               ctl_o,
    output logic [gsi_pkg::T_BITS-1:0]      t_o
);
    import gsi_pkg::*;

    gsi_ctl_t          ctl_reg [1:T_BITS];
    logic [REM_W-1:0]  rem_reg [1:T_BITS];
    logic [DEN_W-1:0]  den_reg [1:T_BITS];
    logic [T_BITS-1:0] q_reg   [1:T_BITS];

    for (genvar i = 0; i < T_BITS; i++) begin : g_stage
        localparam int K = T_BITS - 1 - i;
        gsi_ctl_t          ctl_cur;
        logic [REM_W-1:0]  rem_cur, sh_c, cmp_c;
        logic [DEN_W-1:0]  den_cur;
        logic [T_BITS-1:0] q_cur;
        logic              ge_c;

        if (i == 0) begin : g_first
            assign ctl_cur = ctl_i;
            assign rem_cur = rem_i;
            assign den_cur = den_i;
            assign q_cur   = '0;
        end else begin : g_next
            assign ctl_cur = ctl_reg[i];
            assign rem_cur = rem_reg[i];
            assign den_cur = den_reg[i];
            assign q_cur   = q_reg[i];
        end

        // integer bits compare against a scaled divisor, fraction bits shift the remainder
        if (K >= FRAC_BITS) begin : g_int
            assign sh_c  = rem_cur;
            assign cmp_c = REM_W'(den_cur) << (K - FRAC_BITS);
        end else begin : g_frac
            assign sh_c  = rem_cur << 1;
            assign cmp_c = REM_W'(den_cur);
        end
        assign ge_c = (sh_c >= cmp_c);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i+1] <= '0;
            end else if (en) begin
                ctl_reg[i+1] <= ctl_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge_c ? sh_c - cmp_c : sh_c;
                den_reg[i+1] <= den_cur;
                q_reg[i+1]   <= {q_cur[T_BITS-2:0], ge_c};
            end
        end
    end

    assign ctl_o = ctl_reg[T_BITS];
    assign t_o   = q_reg[T_BITS];

endmodule
`default_nettype wire

[rtl/core/gsi_exp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsi_exp
// Fixed-point exp(-t): one table factor per stage for each set bit of t,
// then the 0..255 scaling and the zero-sigma and far overrides.
// ----------------------------------------------------------------------------
module gsi_exp (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              en,
    input  wire  gsi_pkg::gsi_ctl_t          ctl_i,
    input  wire  [gsi_pkg::T_BITS-1:0]       t_i,
    output logic                             vld_o,
    output logic [gsi_pkg::LEVEL_W-1:0]      level_o
);
    import gsi_pkg::*;

    localparam int PR_W = E_W + 16;
    localparam int LV_W = E_W + LEVEL_W;

    gsi_ctl_t            ctl_reg [1:T_BITS];
    logic [T_BITS-1:0]   t_reg   [1:T_BITS];
    logic [E_W-1:0]      e_reg   [1:T_BITS];
    logic                vld_reg;
    logic [LEVEL_W-1:0]  level_reg;

    for (genvar j = 0; j < T_BITS; j++) begin : g_stage
        gsi_ctl_t          ctl_cur;
        logic [T_BITS-1:0] t_cur;
        logic [E_W-1:0]    e_cur;
        logic [PR_W-1:0]   prod_c;

        if (j == 0) begin : g_first
            assign ctl_cur = ctl_i;
            assign t_cur   = t_i;
            assign e_cur   = E_W'(1 << 16);
        end else begin : g_next
            assign ctl_cur = ctl_reg[j];
            assign t_cur   = t_reg[j];
            assign e_cur   = e_reg[j];
        end

        assign prod_c = PR_W'(e_cur) * PR_W'(exp_factor(5'(j))) + PR_W'(32768);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j+1] <= '0;
            end else if (en) begin
                ctl_reg[j+1] <= ctl_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                t_reg[j+1] <= t_cur;
                e_reg[j+1] <= t_cur[j] ? prod_c[PR_W-1:16] : e_cur;
            end
        end
    end

    gsi_ctl_t           ctl_last;
    logic [LV_W-1:0]    lv_c;
    logic [LEVEL_W:0]   lvl_c;
    logic [LEVEL_W-1:0] sat_c, level_next;

    assign ctl_last = ctl_reg[T_BITS];
    assign lv_c     = (LV_W'(e_reg[T_BITS]) << 8) - LV_W'(e_reg[T_BITS]) + LV_W'(32768);
    assign lvl_c    = lv_c[LV_W-1:16];
    assign sat_c    = lvl_c[LEVEL_W] ? '1 : lvl_c[LEVEL_W-1:0];

    always_comb begin
        if (ctl_last.zsig) begin
            level_next = ctl_last.dz ? '1 : '0;
        end else if (ctl_last.far) begin
            level_next = '0;
        end else begin
            level_next = sat_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= ctl_last.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            level_reg <= level_next;
        end
    end

    assign vld_o   = vld_reg;
    assign level_o = level_reg;

endmodule
`default_nettype wire

[rtl/core/gaussian_spot_intensity.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_spot_intensity
// Grey level of one pixel under a Gaussian spot, one pixel per clock while s_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (s_valid/s_ready) carry a spot position and width in
//   signed Q3.12 and one pixel column and row; each request gives exactly
//   one result request (m_valid/m_ready) with the 8-bit intensity.
//   Results come out in request order. Throughput is one pixel per cycle
//   while the skid entry is empty; every pipeline stage is a register
//   with its valid bit, the divider yields one quotient bit per stage and
//   the exponent applies one table factor per stage.
//   The output register is backed by one skid entry: when m_ready is low
//   the pipeline runs on until a result enters the skid entry, then holds;
//   s_ready drops only while the skid entry is full, and nothing is lost.
//   cfg_we writes frame_size (index 0, clamped to 1..MAX_FRAME_SIDE) or
//   spot_scale (index 1); other indexes are dropped. Write only when idle.
//   Reset clears all valid bits and loads frame_size 256, spot_scale 3277.
// ----------------------------------------------------------------------------
module gaussian_spot_intensity #(
    parameter int MAX_FRAME_SIDE = gsi_pkg::FRAME_SIDE_MAX
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  signed [gsi_pkg::COORD_W-1:0]  s_spot_x,
    input  wire  signed [gsi_pkg::COORD_W-1:0]  s_spot_y,
    input  wire  signed [gsi_pkg::COORD_W-1:0]  s_spot_width,
    input  wire         [gsi_pkg::PIX_W-1:0]    s_pixel_col,
    input  wire         [gsi_pkg::PIX_W-1:0]    s_pixel_row,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic        [gsi_pkg::LEVEL_W-1:0]  m_intensity,
    input  wire                                 cfg_we,
    input  wire         [gsi_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire         [gsi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gsi_pkg::*;

    localparam int FS_W   = $clog2(MAX_FRAME_SIDE + 1);
    localparam int DX_W   = ((FS_W + 16 > 24) ? FS_W + 16 : 24) + 2;
    localparam int D2_W   = 2 * DX_W - 1;
    localparam int SIG_W  = FS_W + 15;
    localparam int DEN_W  = 2 * SIG_W + 5;
    localparam int REM_W  = (D2_W > DEN_W + 3) ? D2_W : DEN_W + 3;
    localparam int FS_RST = (FRAME_SIZE_RST > MAX_FRAME_SIDE) ? MAX_FRAME_SIDE
                                                              : FRAME_SIZE_RST;

    logic [FS_W-1:0]       frame_size_reg;
    logic [SCALE_W-1:0]    spot_scale_reg;
    logic [FRAME_WR_W-1:0] fs_wr_c;

    assign fs_wr_c = cfg_wdata[FRAME_WR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_size_reg <= FS_W'(FS_RST);
            spot_scale_reg <= SCALE_W'(SPOT_SCALE_RST);
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_FRAME_SIZE: begin
                    if (fs_wr_c == '0) begin
                        frame_size_reg <= FS_W'(1);
                    end else if (32'(fs_wr_c) > MAX_FRAME_SIDE) begin
                        frame_size_reg <= FS_W'(MAX_FRAME_SIDE);
                    end else begin
                        frame_size_reg <= FS_W'(fs_wr_c);
                    end
                end
                REG_SPOT_SCALE: spot_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    logic              skid_vld_reg, m_valid_reg;
    logic [LEVEL_W-1:0] skid_data_reg, m_data_reg;
    logic              en;
    gsi_ctl_t          geo_ctl, div_ctl;
    logic [REM_W-1:0]  geo_rem;
    logic [DEN_W-1:0]  geo_den;
    logic [T_BITS-1:0] div_t;
    logic              pipe_vld;
    logic [LEVEL_W-1:0] pipe_level;
    logic              slot_free;

    // advance the whole pipeline unless the skid entry is holding a result
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    gsi_geom #(
        .FS_W (FS_W),
        .DX_W (DX_W),
        .D2_W (D2_W),
        .SIG_W(SIG_W),
        .DEN_W(DEN_W),
        .REM_W(REM_W)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (s_valid),
        .spot_x    (s_spot_x),
        .spot_y    (s_spot_y),
        .spot_width(s_spot_width),
        .pixel_col (s_pixel_col),
        .pixel_row (s_pixel_row),
        .frame_size(frame_size_reg),
        .spot_scale(spot_scale_reg),
        .ctl_o     (geo_ctl),
        .rem_o     (geo_rem),
        .den_o     (geo_den)
    );

    gsi_div #(
        .DEN_W(DEN_W),
        .REM_W(REM_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .ctl_i  (geo_ctl),
        .rem_i  (geo_rem),
        .den_i  (geo_den),
        .ctl_o  (div_ctl),
        .t_o    (div_t)
    );

    gsi_exp u_exp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .ctl_i  (div_ctl),
        .t_i    (div_t),
        .vld_o  (pipe_vld),
        .level_o(pipe_level)
    );

    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (slot_free) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (pipe_vld) begin
            if (slot_free) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (slot_free) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (slot_free) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (pipe_vld) begin
            if (slot_free) begin
                m_data_reg <= pipe_level;
            end else begin
                skid_data_reg <= pipe_level;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_intensity = m_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid entry filled without an output stall");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && m_ready) |=> (m_valid_reg && !skid_vld_reg))
        else $error("skid entry did not move to the output register");

    a_frame_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_size_reg != '0) && (32'(frame_size_reg) <= MAX_FRAME_SIDE))
        else $error("frame size register out of range");
`endif

endmodule
`default_nettype wire
